// ----- rtl/srb_pkg.sv -----
// ----------------------------------------------------------------------------
// srb_pkg: shared types and codes of the sample ring buffer
// Item formats, operation and status codes, and the per-result status group.
// ----------------------------------------------------------------------------
package srb_pkg;

  localparam int TS_W    = 64;
  localparam int PL_W    = 64;
  localparam int CTR_W   = 32;
  localparam int OCC_W   = 9;
  localparam int BEAT_W  = 7;

  // Operation codes.
  localparam logic [2:0] OP_PUSH  = 3'd0;
  localparam logic [2:0] OP_POP   = 3'd1;
  localparam logic [2:0] OP_PEEK  = 3'd2;
  localparam logic [2:0] OP_RANGE = 3'd3;
  localparam logic [2:0] OP_CLEAR = 3'd4;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_DROP  = 2'd2;
  localparam logic [1:0] ST_INVAL = 2'd3;

  // What the back end does with a queued command.
  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    logic [2:0]      opcode;
    logic [TS_W-1:0] sample_timestamp;
    logic [PL_W-1:0] sample_payload;
    logic [7:0]      range_start;
    logic [6:0]      range_count;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [TS_W-1:0]  entry_timestamp;
    logic [PL_W-1:0]  entry_payload;
    logic [OCC_W-1:0] occupancy;
    logic             is_full;
    logic             is_empty;
    logic [CTR_W-1:0] total_pushed;
    logic [CTR_W-1:0] dropped_count;
    logic [CTR_W-1:0] overwrite_count;
    logic [TS_W-1:0]  newest_timestamp;
    logic             last;
  } out_item_t;

  // Status group captured by the front end after each operation.
  typedef struct packed {
    logic [1:0]       status;
    logic [OCC_W-1:0] occupancy;
    logic             is_full;
    logic             is_empty;
    logic [CTR_W-1:0] total_pushed;
    logic [CTR_W-1:0] dropped_count;
    logic [CTR_W-1:0] overwrite_count;
    logic [TS_W-1:0]  newest_timestamp;
  } stat_t;

  function automatic logic [CTR_W-1:0] sat_inc(input logic [CTR_W-1:0] v);
    sat_inc = (v == '1) ? v : v + 1'b1;
  endfunction

endpackage

// ----- rtl/srb_queue.sv -----
// ----------------------------------------------------------------------------
// srb_queue: short command queue
// Small register FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module srb_queue #(
  parameter int WIDTH  = 8,
  parameter int QDEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  output logic             rd_valid,
  output logic [WIDTH-1:0] rd_data,
  input  logic             rd_pop
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int NW = $clog2(QDEPTH + 1);

  logic [WIDTH-1:0] slots [QDEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [NW-1:0]    fill;

  assign full     = (fill == NW'(QDEPTH));
  assign rd_valid = (fill != '0);
  assign rd_data  = slots[rd_ptr];

  // Entry storage; writes are taken only when a slot is free.
  always_ff @(posedge clk) begin
    if (wr_en && !full) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en && !full) begin
        wr_ptr <= (wr_ptr == PW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_pop && rd_valid) begin
        rd_ptr <= (rd_ptr == PW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + NW'(wr_en && !full) - NW'(rd_pop && rd_valid);
    end
  end

endmodule

// ----- rtl/srb_front.sv -----
// ----------------------------------------------------------------------------
// srb_front: operation front end
// Accepts operations, keeps pointers, occupancy and counters, and queues one
// command per operation for the storage back end.
// ----------------------------------------------------------------------------
module srb_front
  import srb_pkg::*;
#(
  parameter int DEPTH         = 256,
  parameter int PAYLOAD_WIDTH = 64,
  parameter int MAX_RANGE     = 64,
  parameter int AW            = $clog2(DEPTH)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  in_item_t                 in_data,
  input  logic                     cfg_valid,
  input  logic                     cfg_data,
  input  logic                     q_full,
  output logic                     cmd_push,
  output cmd_kind_t                cmd_kind,
  output logic [AW-1:0]            cmd_addr,
  output logic [BEAT_W-1:0]        cmd_beats,
  output logic [TS_W-1:0]          cmd_ts,
  output logic [PAYLOAD_WIDTH-1:0] cmd_pl,
  output stat_t                    cmd_stat
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > 8) ? CW : 8;

  // Architectural state.
  logic [AW-1:0]    wp;
  logic [AW-1:0]    rp;
  logic [CW-1:0]    count;
  logic [CTR_W-1:0] pushed;
  logic [CTR_W-1:0] dropped;
  logic [CTR_W-1:0] overwritten;
  logic [TS_W-1:0]  last_ts;
  logic             overwrite_mode;

  logic [AW-1:0]    wp_next;
  logic [AW-1:0]    rp_next;
  logic [CW-1:0]    count_next;
  logic [CTR_W-1:0] pushed_next;
  logic [CTR_W-1:0] dropped_next;
  logic [CTR_W-1:0] overwritten_next;
  logic [TS_W-1:0]  last_ts_next;

  logic              accept;
  logic              full_now;
  logic              empty_now;
  logic [AW-1:0]     wp_inc;
  logic [AW-1:0]     rp_inc;
  logic [AW-1:0]     wp_dec;
  logic [XW-1:0]     start_x;
  logic [XW-1:0]     avail;
  logic [BEAT_W-1:0] cnt_sat;
  logic [XW:0]       base_sum;
  logic [AW-1:0]     base_addr;
  logic [1:0]        status;

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign cmd_push  = accept;
  assign full_now  = (count == CW'(DEPTH));
  assign empty_now = (count == '0);
  assign wp_inc    = (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
  assign rp_inc    = (rp == AW'(DEPTH - 1)) ? '0 : rp + 1'b1;
  assign wp_dec    = (wp == '0) ? AW'(DEPTH - 1) : wp - 1'b1;

  // Range read arguments: saturate the count, clip at the newest entry, and
  // locate the first entry relative to the oldest one.
  assign start_x   = XW'(in_data.range_start);
  assign avail     = XW'(count) - start_x;
  assign cnt_sat   = (in_data.range_count > BEAT_W'(MAX_RANGE)) ?
                     BEAT_W'(MAX_RANGE) : in_data.range_count;
  assign base_sum  = (XW + 1)'(rp) + (XW + 1)'(start_x);
  assign base_addr = (base_sum >= (XW + 1)'(DEPTH)) ?
                     AW'(base_sum - (XW + 1)'(DEPTH)) : AW'(base_sum);

  // Operation decode and next state.
  always_comb begin
    wp_next          = wp;
    rp_next          = rp;
    count_next       = count;
    pushed_next      = pushed;
    dropped_next     = dropped;
    overwritten_next = overwritten;
    last_ts_next     = last_ts;
    cmd_kind         = CMD_NONE;
    cmd_addr         = '0;
    cmd_beats        = BEAT_W'(1);
    status           = ST_OK;
    case (in_data.opcode)
      OP_PUSH: begin
        if (full_now && !overwrite_mode) begin
          dropped_next = sat_inc(dropped);
          status       = ST_DROP;
        end else begin
          cmd_kind     = CMD_WRITE;
          cmd_addr     = wp;
          wp_next      = wp_inc;
          if (full_now) begin
            rp_next          = rp_inc;
            overwritten_next = sat_inc(overwritten);
          end else begin
            count_next = count + 1'b1;
          end
          pushed_next  = sat_inc(pushed);
          last_ts_next = in_data.sample_timestamp;
        end
      end
      OP_POP: begin
        if (empty_now) begin
          status = ST_EMPTY;
        end else begin
          cmd_kind   = CMD_READ;
          cmd_addr   = rp;
          rp_next    = rp_inc;
          count_next = count - 1'b1;
        end
      end
      OP_PEEK: begin
        if (empty_now) begin
          status = ST_EMPTY;
        end else begin
          cmd_kind = CMD_READ;
          cmd_addr = wp_dec;
        end
      end
      OP_RANGE: begin
        if (in_data.range_count == '0 || start_x >= XW'(count)) begin
          status = ST_INVAL;
        end else begin
          cmd_kind  = CMD_READ;
          cmd_addr  = base_addr;
          cmd_beats = (XW'(cnt_sat) < avail) ? cnt_sat : BEAT_W'(avail);
        end
      end
      OP_CLEAR: begin
        wp_next    = '0;
        rp_next    = '0;
        count_next = '0;
      end
      default: begin
        status = ST_INVAL;
      end
    endcase
  end

  // Command payload, with the status as it stands after the operation.
  assign cmd_ts = in_data.sample_timestamp;
  assign cmd_pl = in_data.sample_payload[PAYLOAD_WIDTH-1:0];

  always_comb begin
    cmd_stat.status           = status;
    cmd_stat.occupancy        = OCC_W'(count_next);
    cmd_stat.is_full          = (count_next == CW'(DEPTH));
    cmd_stat.is_empty         = (count_next == '0);
    cmd_stat.total_pushed     = pushed_next;
    cmd_stat.dropped_count    = dropped_next;
    cmd_stat.overwrite_count  = overwritten_next;
    cmd_stat.newest_timestamp = last_ts_next;
  end

  // State update on each transfer and on configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp             <= '0;
      rp             <= '0;
      count          <= '0;
      pushed         <= '0;
      dropped        <= '0;
      overwritten    <= '0;
      last_ts        <= '0;
      overwrite_mode <= 1'b0;
    end else begin
      if (cfg_valid) begin
        overwrite_mode <= cfg_data;
      end
      if (accept) begin
        wp          <= wp_next;
        rp          <= rp_next;
        count       <= count_next;
        pushed      <= pushed_next;
        dropped     <= dropped_next;
        overwritten <= overwritten_next;
        last_ts     <= last_ts_next;
      end
    end
  end

`ifndef SYNTHESIS
  // Occupancy never exceeds the store.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("occupancy above depth");

  // The write pointer sits occupancy entries past the read pointer.
  a_ptr_relation: assert property (@(posedge clk) disable iff (rst)
    ((AW + 2)'(rp) + (AW + 2)'(count) == (AW + 2)'(wp)) ||
    ((AW + 2)'(rp) + (AW + 2)'(count) == (AW + 2)'(wp) + (AW + 2)'(DEPTH)))
    else $error("pointers disagree with occupancy");

  // A clear empties the store.
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    accept && in_data.opcode == OP_CLEAR |=> count == '0 && wp == '0 && rp == '0)
    else $error("clear left entries behind");
`endif

endmodule

// ----- rtl/srb_back.sv -----
// ----------------------------------------------------------------------------
// srb_back: storage back end
// Holds the entry store, carries out queued writes and reads in order, and
// drives the registered result stage.
// ----------------------------------------------------------------------------
module srb_back
  import srb_pkg::*;
#(
  parameter int DEPTH         = 256,
  parameter int PAYLOAD_WIDTH = 64,
  parameter int AW            = $clog2(DEPTH)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     head_valid,
  input  cmd_kind_t                head_kind,
  input  logic [AW-1:0]            head_addr,
  input  logic [BEAT_W-1:0]        head_beats,
  input  logic [TS_W-1:0]          head_ts,
  input  logic [PAYLOAD_WIDTH-1:0] head_pl,
  input  stat_t                    head_stat,
  output logic                     head_pop,
  output logic                     out_valid,
  input  logic                     out_ready,
  output out_item_t                out_data
);

  localparam int SW = ((AW > BEAT_W - 1) ? AW : BEAT_W - 1) + 1;

  // Entry store.
  logic [TS_W-1:0]          mem_ts [DEPTH];
  logic [PAYLOAD_WIDTH-1:0] mem_pl [DEPTH];

  logic [BEAT_W-2:0]        beat;
  logic                     issue;
  logic                     last_beat;
  logic [SW-1:0]            rd_sum;
  logic [AW-1:0]            rd_addr;

  // Result stage.
  logic                     b_valid;
  logic                     b_last;
  logic                     b_read;
  stat_t                    b_stat;
  logic [TS_W-1:0]          rd_ts;
  logic [PAYLOAD_WIDTH-1:0] rd_pl;

  assign issue     = head_valid && (!b_valid || out_ready);
  assign last_beat = (BEAT_W'(beat) + 1'b1 == head_beats);
  assign head_pop  = issue && last_beat;
  assign rd_sum    = SW'(head_addr) + SW'(beat);
  assign rd_addr   = (rd_sum >= SW'(DEPTH)) ? AW'(rd_sum - SW'(DEPTH)) : AW'(rd_sum);

  // Store write and registered read, one command beat per cycle unless the result stalls.
  always_ff @(posedge clk) begin
    if (issue && head_kind == CMD_WRITE) begin
      mem_ts[head_addr] <= head_ts;
      mem_pl[head_addr] <= head_pl;
    end
    if (issue && head_kind == CMD_READ) begin
      rd_ts <= mem_ts[rd_addr];
      rd_pl <= mem_pl[rd_addr];
    end
  end

  // Beat counter within a range read.
  always_ff @(posedge clk) begin
    if (rst) begin
      beat <= '0;
    end else if (issue) begin
      beat <= last_beat ? '0 : beat + 1'b1;
    end
  end

  // Result register; holds while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (issue) begin
      b_valid <= 1'b1;
    end else if (out_ready) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      b_last <= last_beat;
      b_read <= (head_kind == CMD_READ);
      b_stat <= head_stat;
    end
  end

  // Result fields.
  assign out_valid = b_valid;

  always_comb begin
    out_data.status           = b_stat.status;
    out_data.entry_timestamp  = b_read ? rd_ts : '0;
    out_data.entry_payload    = b_read ? PL_W'(rd_pl) : '0;
    out_data.occupancy        = b_stat.occupancy;
    out_data.is_full          = b_stat.is_full;
    out_data.is_empty         = b_stat.is_empty;
    out_data.total_pushed     = b_stat.total_pushed;
    out_data.dropped_count    = b_stat.dropped_count;
    out_data.overwrite_count  = b_stat.overwrite_count;
    out_data.newest_timestamp = b_stat.newest_timestamp;
    out_data.last             = b_last;
  end

`ifndef SYNTHESIS
  // Queued commands always carry at least one beat.
  a_beats_nonzero: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> head_beats != '0)
    else $error("command with no beats");

  // Writes are single-beat and never start mid-range.
  a_write_single: assert property (@(posedge clk) disable iff (rst)
    issue && head_kind == CMD_WRITE |-> beat == '0)
    else $error("write issued inside a range");

  // The final beat of a command shows up marked last.
  a_last_marked: assert property (@(posedge clk) disable iff (rst)
    issue && last_beat |=> out_valid && b_last)
    else $error("final beat not marked last");
`endif

endmodule

// ----- rtl/sample_ring_buffer.sv -----
// ----------------------------------------------------------------------------
// sample_ring_buffer: circular timestamped sample store
// Top level: front end, command queue and storage back end.
// ----------------------------------------------------------------------------
// Usage:
//   Operations enter on in_valid/in_ready as one in_item_t each: push, pop
//   oldest, peek newest, range read, clear. Results leave on
//   out_valid/out_ready as out_item_t; each operation yields one result,
//   a successful range read one per entry, and the final one has last set.
//   cfg_valid/cfg_ready writes the overwrite-when-full mode bit; it is always
//   ready and should be written only while no operation is in flight.
//   Each operation passes the command queue, then the result register, before
//   its first result. The back end issues one store access per cycle while
//   results are taken, so single-result operations sustain one per cycle and
//   a range read uses one access per entry; the single store read port sets
//   that rate. A four-entry command queue lets the front end keep taking
//   operations meanwhile. When the receiver stalls, the result register
//   holds, the queue fills, and in_ready drops once the queue is full.
//   Reset clears pointers, occupancy, counters and the mode bit; the entry
//   store itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module sample_ring_buffer
  import srb_pkg::*;
#(
  parameter int DEPTH         = 256,
  parameter int PAYLOAD_WIDTH = 64,
  parameter int MAX_RANGE     = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data
);

  localparam int AW     = $clog2(DEPTH);
  localparam int ST_W   = $bits(stat_t);
  localparam int CMD_W  = 2 + AW + BEAT_W + TS_W + PAYLOAD_WIDTH + ST_W;
  localparam int QDEPTH = 4;

  logic                     q_full;
  logic                     cmd_push;
  cmd_kind_t                cmd_kind;
  logic [AW-1:0]            cmd_addr;
  logic [BEAT_W-1:0]        cmd_beats;
  logic [TS_W-1:0]          cmd_ts;
  logic [PAYLOAD_WIDTH-1:0] cmd_pl;
  stat_t                    cmd_stat;
  logic [CMD_W-1:0]         cmd_vec;

  logic                     head_valid;
  logic                     head_pop;
  logic [CMD_W-1:0]         head_vec;
  cmd_kind_t                head_kind;
  logic [AW-1:0]            head_addr;
  logic [BEAT_W-1:0]        head_beats;
  logic [TS_W-1:0]          head_ts;
  logic [PAYLOAD_WIDTH-1:0] head_pl;
  stat_t                    head_stat;

  assign cfg_ready = 1'b1;

  // Front end: decode and bookkeeping.
  srb_front #(
    .DEPTH         (DEPTH),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH),
    .MAX_RANGE     (MAX_RANGE),
    .AW            (AW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .cmd_push  (cmd_push),
    .cmd_kind  (cmd_kind),
    .cmd_addr  (cmd_addr),
    .cmd_beats (cmd_beats),
    .cmd_ts    (cmd_ts),
    .cmd_pl    (cmd_pl),
    .cmd_stat  (cmd_stat)
  );

  // Command packing for the queue.
  assign cmd_vec = {cmd_kind, cmd_addr, cmd_beats, cmd_ts, cmd_pl, cmd_stat};

  srb_queue #(
    .WIDTH  (CMD_W),
    .QDEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cmd_push),
    .wr_data  (cmd_vec),
    .full     (q_full),
    .rd_valid (head_valid),
    .rd_data  (head_vec),
    .rd_pop   (head_pop)
  );

  // Command unpacking at the queue head.
  assign head_kind  = cmd_kind_t'(head_vec[CMD_W-1 -: 2]);
  assign head_addr  = head_vec[CMD_W-3 -: AW];
  assign head_beats = head_vec[CMD_W-3-AW -: BEAT_W];
  assign head_ts    = head_vec[PAYLOAD_WIDTH+ST_W +: TS_W];
  assign head_pl    = head_vec[ST_W +: PAYLOAD_WIDTH];
  assign head_stat  = stat_t'(head_vec[ST_W-1:0]);

  // Back end: entry store and result stage.
  srb_back #(
    .DEPTH         (DEPTH),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH),
    .AW            (AW)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_kind  (head_kind),
    .head_addr  (head_addr),
    .head_beats (head_beats),
    .head_ts    (head_ts),
    .head_pl    (head_pl),
    .head_stat  (head_stat),
    .head_pop   (head_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
